>>> sv/sqlss_pkg.sv
package sqlss_pkg;

	localparam int PART_SIZE_BITS = 32;

	localparam logic [31:0] MAX_PART_RESET = 32'd1048576;
	localparam logic [30:0] GIB_LIMIT      = 31'd1073741824;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h27;
	localparam logic [7:0] CH_SEMI      = 8'h3B;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_PART = 2'd1,
		ERR_GIB  = 2'd2
	} error_code_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [30:0] statement_bytes;
		logic        starts_new_part;
		logic [31:0] part_number;
		logic [31:0] part_fill;
		logic        at_stream_end;
		error_code_t error_code;
	} out_item_t;

endpackage

>>> sv/sqlss_core.sv
module sqlss_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sqlss_pkg::in_item_t item,
	input  logic [31:0]         max_part_bytes,
	output logic                res_valid,
	output sqlss_pkg::out_item_t res,
	output logic                stopped
);
	import sqlss_pkg::*;

	logic                      after_bs_q, in_quote_q, stopped_q;
	logic [30:0]               stmt_cnt_q;
	logic [31:0]               fill_q;
	logic [PART_SIZE_BITS-1:0] part_q;

	logic                      n_bs, n_quote, n_stop, hit, semi;
	logic [30:0]               n_cnt, cnt;
	logic [31:0]               n_fill;
	logic [PART_SIZE_BITS-1:0] n_part;
	logic [32:0]               sum;

	always_comb begin
		n_bs    = after_bs_q;
		n_quote = in_quote_q;
		n_stop  = stopped_q;
		n_cnt   = stmt_cnt_q;
		n_fill  = fill_q;
		n_part  = part_q;
		hit     = 1'b0;
		semi    = 1'b0;

		if (after_bs_q) begin
			n_bs = 1'b0;
		end else if (item.data_byte == CH_BACKSLASH) begin
			n_bs = 1'b1;
		end else if (item.data_byte == CH_QUOTE) begin
			n_quote = !in_quote_q;
		end else if (item.data_byte == CH_SEMI && !in_quote_q) begin
			semi = 1'b1;
		end

		cnt = stmt_cnt_q + 31'd1;
		sum = {1'b0, fill_q} + {2'b00, cnt};

		res.statement_bytes = cnt;
		res.starts_new_part = 1'b0;
		res.part_number     = 32'(part_q);
		res.part_fill       = fill_q;
		res.at_stream_end   = item.last_byte;
		res.error_code      = ERR_NONE;

		if (!stopped_q) begin
			if (!semi && cnt > GIB_LIMIT) begin
				hit            = 1'b1;
				res.error_code = ERR_GIB;
				n_stop         = 1'b1;
				n_cnt          = cnt;
			end else if (semi || item.last_byte) begin
				hit = 1'b1;
				if ({1'b0, cnt} > max_part_bytes) begin
					res.error_code = ERR_PART;
					n_stop         = 1'b1;
					n_cnt          = cnt;
				end else begin
					if (fill_q == 32'd0) begin
						n_fill              = {1'b0, cnt};
						res.starts_new_part = 1'b1;
					end else if (sum > {1'b0, max_part_bytes}) begin
						n_part              = part_q + 1'b1;
						n_fill              = {1'b0, cnt};
						res.starts_new_part = 1'b1;
					end else begin
						n_fill = sum[31:0];
					end
					res.part_number = 32'(n_part);
					res.part_fill   = n_fill;
					n_cnt           = '0;
					n_bs            = 1'b0;
					n_quote         = 1'b0;
					// stream end: next byte starts over in part 0
					if (item.last_byte) begin
						n_fill = '0;
						n_part = '0;
					end
				end
			end else begin
				n_cnt = cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_bs_q <= 1'b0;
			in_quote_q <= 1'b0;
			stopped_q  <= 1'b0;
			stmt_cnt_q <= '0;
			fill_q     <= '0;
			part_q     <= '0;
		end else if (fire) begin
			after_bs_q <= n_bs;
			in_quote_q <= n_quote;
			stopped_q  <= n_stop;
			stmt_cnt_q <= n_cnt;
			fill_q     <= n_fill;
			part_q     <= n_part;
		end
	end

	assign res_valid = fire && hit;
	assign stopped   = stopped_q;

endmodule

>>> sv/sqlss_outreg.sv
module sqlss_outreg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sqlss_pkg::out_item_t load_data,
	output logic                 advance,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sqlss_pkg::out_item_t out_data
);
	import sqlss_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// register is free when empty or its request leaves this cycle
	assign advance = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> sv/sql_statement_splitter.sv
// An accepted request is registered in the input stage, its result (if any)
// in the output register. Throughput: one byte per cycle while the output
// is not stalled; the per-byte update (flags, adds, compares) is combinational.
// Reset: asynchronous, active low; clears all stream and part state, the
// stopped flag and both valids, and sets max_part_bytes to 1048576.
module sql_statement_splitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sqlss_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sqlss_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [31:0]          cfg_data
);
	import sqlss_pkg::*;

	logic        s1_valid;
	in_item_t    item_s1;
	logic [31:0] max_part_q;
	logic        advance, fire, take, res_valid, core_stopped;
	out_item_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_part_q <= MAX_PART_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_part_q <= cfg_data;
		end
	end

	assign fire     = s1_valid && advance;
	assign in_stall = s1_valid && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= take || (s1_valid && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_data;
		end
	end

	sqlss_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.item           (item_s1),
		.max_part_bytes (max_part_q),
		.res_valid      (res_valid),
		.res            (res),
		.stopped        (core_stopped)
	);

	sqlss_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_data (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		core_stopped |-> !res_valid)
		else $error("result produced while stopped");

	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.error_code != ERR_NONE |=> core_stopped)
		else $error("error did not stop the block");

	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> s1_valid)
		else $error("accepted request lost from input stage");

	a_fill_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code == ERR_NONE
		|-> out_data.part_fill >= {1'b0, out_data.statement_bytes})
		else $error("part fill below statement length");

endmodule
